// ===== hdl/dna_codeword_greedy_filter_assert.svh =====
// assertion macros shared by the filter's checking code
`ifndef DNA_CODEWORD_GREEDY_FILTER_ASSERT_SVH
`define DNA_CODEWORD_GREEDY_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define DCGF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcgf check failed");

`define DCGF_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dcgf check failed");

`else

`define DCGF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define DCGF_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hdl/dcgf_pkg.sv =====
package dcgf_pkg;

    localparam int MAX_WORDS  = 256;
    localparam int WORD_BASES = 8;
    localparam int WORD_BITS  = 2 * WORD_BASES;
    localparam int ADDR_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int DIST_W     = $clog2(WORD_BASES + 1);
    localparam int CFG_W      = 4;
    localparam int CMP_W      = (DIST_W > CFG_W) ? DIST_W : CFG_W;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GC_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 2'd1;

    localparam logic [CFG_W-1:0] GC_TARGET_RST = 4'd4;
    localparam logic [CFG_W-1:0] MIN_DIST_RST  = 4'd4;

    typedef enum logic [2:0] {
        RSN_OK      = 3'd0,
        RSN_GC      = 3'd1,
        RSN_SELF_RC = 3'd2,
        RSN_NEAR    = 3'd3,
        RSN_NEAR_RC = 3'd4,
        RSN_FULL    = 3'd5
    } rsn_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 clear;
        rsn_t                 pre_rsn;
    } item_t;

    function automatic logic [WORD_BITS-1:0] rev_comp(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BASES; i++)
        begin
            r[2*i +: 2] = w[2*(WORD_BASES-1-i) +: 2] ^ 2'b01;
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] hamming(input logic [WORD_BITS-1:0] a,
                                                  input logic [WORD_BITS-1:0] b);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BASES; i++)
        begin
            if (a[2*i +: 2] != b[2*i +: 2])
            begin
                n = n + DIST_W'(1);
            end
        end
        return n;
    endfunction

    function automatic logic [DIST_W-1:0] gc_count(input logic [WORD_BITS-1:0] w);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BASES; i++)
        begin
            // C and G have the upper code bit set
            if (w[2*i + 1])
            begin
                n = n + DIST_W'(1);
            end
        end
        return n;
    endfunction

    function automatic logic too_close(input logic [DIST_W-1:0] ham_dist,
                                       input logic [CFG_W-1:0]  min_dist);
        return CMP_W'(ham_dist) < CMP_W'(min_dist);
    endfunction

endpackage

// ===== hdl/dna_codeword_greedy_filter.sv =====
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   candidate_word, clear_set
// out       output     out_valid / out_stall accepted, reason, set_size
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// an item whose checks pass up front is scanned in the back end against the stored words:
// one block ram read per stored word, pipelined one per cycle
// an item rejected on c+g count or self reverse complement skips the scan and goes to the done state
// a two-entry queue parts the input from the scan, so input takes items during a scan
// reset clears the word count and config to defaults; the word store is not cleared
// a stalled result holds the next item in the done state until the result is taken
module dna_codeword_greedy_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dcgf_pkg::WORD_BITS-1:0]    candidate_word,
    input  logic                              clear_set,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic [2:0]                        reason,
    output logic [dcgf_pkg::SIZE_W-1:0]       set_size,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcgf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcgf_pkg::CFG_W-1:0]        cfg_data
);

`include "dna_codeword_greedy_filter_assert.svh"

    logic [dcgf_pkg::CFG_W-1:0] gc_target_reg;
    logic [dcgf_pkg::CFG_W-1:0] gc_target_next;
    logic [dcgf_pkg::CFG_W-1:0] min_dist_reg;
    logic [dcgf_pkg::CFG_W-1:0] min_dist_next;

    logic            push_valid;
    dcgf_pkg::item_t push_item;
    logic            q_full;
    logic            pop_valid;
    dcgf_pkg::item_t pop_item;
    logic            pop_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gc_target_next = gc_target_reg;
        min_dist_next  = min_dist_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dcgf_pkg::REG_GC_TARGET: gc_target_next = cfg_data;
                dcgf_pkg::REG_MIN_DIST:  min_dist_next  = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gc_target_reg <= dcgf_pkg::GC_TARGET_RST;
            min_dist_reg  <= dcgf_pkg::MIN_DIST_RST;
        end
        else
        begin
            gc_target_reg <= gc_target_next;
            min_dist_reg  <= min_dist_next;
        end
    end

    dcgf_front u_front
    (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .candidate_word (candidate_word),
        .clear_set      (clear_set),
        .gc_target      (gc_target_reg),
        .min_distance   (min_dist_reg),
        .push_valid     (push_valid),
        .push_item      (push_item),
        .q_full         (q_full)
    );

    dcgf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    dcgf_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_item     (pop_item),
        .pop_ready    (pop_ready),
        .min_distance (min_dist_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .reason       (reason),
        .set_size     (set_size)
    );

    // an appended word always leaves a non-empty set and an ok reason
    `DCGF_ASSERT_IMPLIES(a_acc_ok, clk, rst_n, out_valid && accepted, reason == dcgf_pkg::RSN_OK && set_size != '0)
    // a full-set rejection only happens at capacity
    `DCGF_ASSERT_IMPLIES(a_full_size, clk, rst_n, out_valid && reason == dcgf_pkg::RSN_FULL, set_size == dcgf_pkg::SIZE_W'(dcgf_pkg::MAX_WORDS))
    // the set never grows past capacity
    `DCGF_ASSERT_NEVER(a_size_cap, clk, rst_n, out_valid && set_size > dcgf_pkg::SIZE_W'(dcgf_pkg::MAX_WORDS))

endmodule

// ===== hdl/dcgf_front.sv =====
module dcgf_front
(
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dcgf_pkg::WORD_BITS-1:0] candidate_word,
    input  logic                          clear_set,
    input  logic [dcgf_pkg::CFG_W-1:0]    gc_target,
    input  logic [dcgf_pkg::CFG_W-1:0]    min_distance,
    output logic                          push_valid,
    output dcgf_pkg::item_t               push_item,
    input  logic                          q_full
);

    logic [dcgf_pkg::DIST_W-1:0] gc_n;
    logic [dcgf_pkg::DIST_W-1:0] self_dist;
    logic                        gc_bad;

    assign gc_n      = dcgf_pkg::gc_count(candidate_word);
    assign self_dist = dcgf_pkg::hamming(candidate_word, dcgf_pkg::rev_comp(candidate_word));
    assign gc_bad    = dcgf_pkg::CMP_W'(gc_n) != dcgf_pkg::CMP_W'(gc_target);

    always_comb
    begin
        push_item.word  = candidate_word;
        push_item.clear = clear_set;
        if (gc_bad)
        begin
            push_item.pre_rsn = dcgf_pkg::RSN_GC;
        end
        else if (dcgf_pkg::too_close(self_dist, min_distance))
        begin
            push_item.pre_rsn = dcgf_pkg::RSN_SELF_RC;
        end
        else
        begin
            push_item.pre_rsn = dcgf_pkg::RSN_OK;
        end
    end

    assign push_valid = in_valid;
    assign in_stall   = q_full;

endmodule

// ===== hdl/dcgf_queue.sv =====
module dcgf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  dcgf_pkg::item_t push_item,
    output logic            full,
    output logic            pop_valid,
    output dcgf_pkg::item_t pop_item,
    input  logic            pop_ready
);

    dcgf_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            do_push;
    logic            do_pop;

    assign full      = fill_reg == 2'd2;
    assign pop_valid = fill_reg != 2'd0;
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/dcgf_back.sv =====
module dcgf_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    input  dcgf_pkg::item_t               pop_item,
    output logic                          pop_ready,
    input  logic [dcgf_pkg::CFG_W-1:0]    min_distance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [2:0]                    reason,
    output logic [dcgf_pkg::SIZE_W-1:0]   set_size
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [dcgf_pkg::WORD_BITS-1:0] word_reg;
    logic [dcgf_pkg::WORD_BITS-1:0] word_next;
    dcgf_pkg::rsn_t                 rsn_reg;
    dcgf_pkg::rsn_t                 rsn_next;
    logic [dcgf_pkg::CNT_W-1:0]     count_reg;
    logic [dcgf_pkg::CNT_W-1:0]     count_next;
    logic [dcgf_pkg::CNT_W-1:0]     issue_reg;
    logic [dcgf_pkg::CNT_W-1:0]     issue_next;
    logic                           pend_reg;
    logic                           pend_next;
    logic [dcgf_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_acc_reg;
    logic                           out_acc_next;
    dcgf_pkg::rsn_t                 out_rsn_reg;
    dcgf_pkg::rsn_t                 out_rsn_next;
    logic [dcgf_pkg::CNT_W-1:0]     out_size_reg;
    logic [dcgf_pkg::CNT_W-1:0]     out_size_next;

    logic [dcgf_pkg::WORD_BITS-1:0] mem [dcgf_pkg::MAX_WORDS];

    logic                           rd_en;
    logic                           wr_en;
    logic                           out_free;
    logic                           near;
    logic                           near_rc;
    logic [dcgf_pkg::CNT_W-1:0]     pop_count;
    dcgf_pkg::rsn_t                 final_rsn;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop_ready = state_reg == ST_IDLE;
    assign pop_count = pop_item.clear ? '0 : count_reg;
    assign rd_en     = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign near      = dcgf_pkg::too_close(dcgf_pkg::hamming(word_reg, rd_data_reg),
                                           min_distance);
    assign near_rc   = dcgf_pkg::too_close(
                           dcgf_pkg::hamming(word_reg, dcgf_pkg::rev_comp(rd_data_reg)),
                           min_distance);
    assign final_rsn = (rsn_reg == dcgf_pkg::RSN_OK &&
                        count_reg == dcgf_pkg::CNT_W'(dcgf_pkg::MAX_WORDS))
                       ? dcgf_pkg::RSN_FULL : rsn_reg;

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        rsn_next       = rsn_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_acc_next   = out_acc_reg;
        out_rsn_next   = out_rsn_reg;
        out_size_next  = out_size_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    word_next  = pop_item.word;
                    rsn_next   = pop_item.pre_rsn;
                    count_next = pop_count;
                    issue_next = '0;
                    if (pop_item.pre_rsn != dcgf_pkg::RSN_OK || pop_count == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle, the previous read checked alongside
                pend_next = rd_en;
                if (rd_en)
                begin
                    issue_next = issue_reg + dcgf_pkg::CNT_W'(1);
                end
                if (pend_reg && near)
                begin
                    rsn_next   = dcgf_pkg::RSN_NEAR;
                    state_next = ST_DONE;
                end
                else if (pend_reg && near_rc)
                begin
                    rsn_next   = dcgf_pkg::RSN_NEAR_RC;
                    state_next = ST_DONE;
                end
                else if (!rd_en)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rsn_next   = final_rsn;
                    out_acc_next   = final_rsn == dcgf_pkg::RSN_OK;
                    if (final_rsn == dcgf_pkg::RSN_OK)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + dcgf_pkg::CNT_W'(1);
                    end
                    out_size_next = (final_rsn == dcgf_pkg::RSN_OK)
                                    ? count_reg + dcgf_pkg::CNT_W'(1) : count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rsn_reg       <= dcgf_pkg::RSN_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            rsn_reg       <= rsn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        out_acc_reg  <= out_acc_next;
        out_rsn_reg  <= out_rsn_next;
        out_size_reg <= out_size_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[dcgf_pkg::ADDR_W-1:0]] <= word_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[dcgf_pkg::ADDR_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = out_acc_reg;
    assign reason    = out_rsn_reg;
    assign set_size  = dcgf_pkg::SIZE_W'(out_size_reg);

endmodule
